[src/bsa_pkg.sv]
// Shared types, sizes and codes of the banker's safety allocator.
package bsa_pkg;

    localparam int MAX_PROCS   = 16;
    localparam int MAX_RES     = 8;
    localparam int AMOUNT_BITS = 16;

    localparam int P_W    = $clog2(MAX_PROCS);
    localparam int R_W    = $clog2(MAX_RES);
    localparam int ADDR_W = P_W + R_W;
    localparam int DEPTH  = MAX_PROCS * MAX_RES;

    localparam logic [1:0] OP_SET_FREE = 2'd0;
    localparam logic [1:0] OP_LOAD_ROW = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;
    localparam logic [1:0] OP_REQUEST  = 2'd3;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_SAFE      = 3'd1;
    localparam logic [2:0] ST_UNSAFE    = 3'd2;
    localparam logic [2:0] ST_GRANTED   = 3'd3;
    localparam logic [2:0] ST_ROLLBACK  = 3'd4;
    localparam logic [2:0] ST_OVER_NEED = 3'd5;
    localparam logic [2:0] ST_OVER_FREE = 3'd6;
    localparam logic [2:0] ST_BAD_ROW   = 3'd7;

    localparam logic CFG_PROC_COUNT = 1'b0;
    localparam logic CFG_RES_COUNT  = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  proc_index;
        logic [2:0]  res_index;
        logic [15:0] amount;
        logic [15:0] max_claim;
        logic        req_last;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] order_proc;
        logic       last;
    } t_out_beat;

endpackage

[src/bsa_ram.sv]
// Generic single-port-write, registered-read RAM.
module bsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/banker_safety_allocator.sv]
// Top level of the banker's safety allocator: command decode, tables and safety sequencer.
// One input beat is taken at a time and its results leave through an output register, so a
// new beat is accepted while the last result still waits. Free-count writes, row loads and
// non-final request elements answer through the result state and the output register. A
// safety query runs a sequencer over the allocation and need RAMs: for each unfinished
// process it reads and checks each resource in turn for the fit check and, if the process
// fits, reads each resource again to add its allocation back, while a finished process is
// skipped; up to n passes are made over n processes, and a safe result leaves as one beat
// per process in the safe order. A final request element adds a need and free check per
// resource, a pass to apply it, the safety check, and a pass to roll it back if unsafe. Reset
// clears the tables at once through per-entry valid bits, so no clearing pass follows reset.
module banker_safety_allocator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bsa_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bsa_pkg::t_out_beat  o_out_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [4:0]          i_cfg_data
);

    localparam int AW = bsa_pkg::AMOUNT_BITS;
    localparam int PW = bsa_pkg::P_W;
    localparam int RW = bsa_pkg::R_W;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_CS_INIT = 13'b0000000000010,
        S_CS_RD   = 13'b0000000000100,
        S_CS_CHK  = 13'b0000000001000,
        S_CS_ARD  = 13'b0000000010000,
        S_CS_ADD  = 13'b0000000100000,
        S_RQ_RD   = 13'b0000001000000,
        S_RQ_CHK  = 13'b0000010000000,
        S_AP_RD   = 13'b0000100000000,
        S_AP_WR   = 13'b0001000000000,
        S_RB_RD   = 13'b0010000000000,
        S_RB_WR   = 13'b0100000000000,
        S_PUT     = 13'b1000000000000
    } t_state;

    t_state                      r_state;
    logic [4:0]                  r_proc_cnt;
    logic [3:0]                  r_res_cnt;
    logic [AW-1:0]               r_free [bsa_pkg::MAX_RES];
    logic [AW-1:0]               r_req  [bsa_pkg::MAX_RES];
    logic [AW-1:0]               r_work [bsa_pkg::MAX_RES];
    logic [bsa_pkg::MAX_PROCS-1:0] r_fin;
    logic [3:0]                  r_ord  [bsa_pkg::MAX_PROCS];
    logic [bsa_pkg::DEPTH-1:0]   r_vld;
    logic                        r_rd_vld;
    logic [PW-1:0]               r_row;
    logic [PW-1:0]               r_req_p;
    logic [RW-1:0]               r_j;
    logic [PW:0]                 r_done;
    logic                        r_prog;
    logic                        r_mode_req;
    logic                        r_multi;
    logic                        r_clr;
    logic [PW-1:0]               r_k;
    bsa_pkg::t_out_beat          r_res;
    logic                        r_ov;
    bsa_pkg::t_out_beat          r_od;

    logic [PW:0]                 w_eff_n;
    logic [RW:0]                 w_eff_m;
    logic [PW-1:0]               w_n_last;
    logic [RW-1:0]               w_m_last;
    logic                        w_use_req;
    logic [bsa_pkg::ADDR_W-1:0]  w_raddr;
    logic [bsa_pkg::ADDR_W-1:0]  w_waddr;
    logic                        w_we;
    logic [AW-1:0]               w_walloc;
    logic [AW-1:0]               w_wneed;
    logic [AW-1:0]               w_alloc_raw;
    logic [AW-1:0]               w_need_raw;
    logic [AW-1:0]               w_alloc;
    logic [AW-1:0]               w_need;
    logic [AW:0]                 w_sum;
    logic [AW-1:0]               w_sat;
    logic                        w_fail;
    logic                        w_adv;
    logic                        w_prog_now;
    logic [PW:0]                 w_done_now;
    logic                        w_accept;
    logic                        w_slot;
    logic                        w_j_last;

    always_comb begin
        if (r_proc_cnt == 5'd0) begin
            w_eff_n = (PW+1)'(1);
        end else if (r_proc_cnt > 5'(bsa_pkg::MAX_PROCS)) begin
            w_eff_n = (PW+1)'(bsa_pkg::MAX_PROCS);
        end else begin
            w_eff_n = (PW+1)'(r_proc_cnt);
        end
        if (r_res_cnt == 4'd0) begin
            w_eff_m = (RW+1)'(1);
        end else if (r_res_cnt > 4'(bsa_pkg::MAX_RES)) begin
            w_eff_m = (RW+1)'(bsa_pkg::MAX_RES);
        end else begin
            w_eff_m = (RW+1)'(r_res_cnt);
        end
    end

    assign w_n_last = PW'(w_eff_n - (PW+1)'(1));
    assign w_m_last = RW'(w_eff_m - (RW+1)'(1));
    assign w_j_last = (r_j == w_m_last);

    assign w_use_req = (r_state == S_RQ_RD) || (r_state == S_RQ_CHK) || (r_state == S_AP_RD) ||
                       (r_state == S_AP_WR) || (r_state == S_RB_RD) || (r_state == S_RB_WR);
    assign w_raddr   = {(w_use_req ? r_req_p : r_row), r_j};
    assign w_accept  = i_in_valid && (r_state == S_IDLE);
    assign w_slot    = !r_ov || !i_out_stall;

    assign w_alloc = r_rd_vld ? w_alloc_raw : '0;
    assign w_need  = r_rd_vld ? w_need_raw  : '0;

    always_comb begin
        w_we     = 1'b0;
        w_waddr  = w_raddr;
        w_walloc = w_alloc + r_req[r_j];
        w_wneed  = w_need - r_req[r_j];
        if (r_state == S_AP_WR) begin
            w_we = 1'b1;
        end else if (r_state == S_RB_WR) begin
            w_we     = 1'b1;
            w_walloc = w_alloc - r_req[r_j];
            w_wneed  = w_need + r_req[r_j];
        end else if (w_accept && (i_in_data.opcode == bsa_pkg::OP_LOAD_ROW) &&
                     !(i_in_data.max_claim < i_in_data.amount)) begin
            w_we     = 1'b1;
            w_waddr  = {i_in_data.proc_index[PW-1:0], i_in_data.res_index[RW-1:0]};
            w_walloc = i_in_data.amount;
            w_wneed  = i_in_data.max_claim - i_in_data.amount;
        end
    end

    bsa_ram #(.WIDTH(AW), .DEPTH(bsa_pkg::DEPTH)) u_alloc_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_walloc),
        .i_raddr (w_raddr),
        .o_rdata (w_alloc_raw)
    );

    bsa_ram #(.WIDTH(AW), .DEPTH(bsa_pkg::DEPTH)) u_need_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wneed),
        .i_raddr (w_raddr),
        .o_rdata (w_need_raw)
    );

    assign w_sum      = {1'b0, r_work[r_j]} + {1'b0, w_alloc};
    assign w_sat      = w_sum[AW] ? '1 : w_sum[AW-1:0];
    assign w_fail     = w_need > r_work[r_j];
    assign w_adv      = ((r_state == S_CS_RD) && r_fin[r_row]) ||
                        ((r_state == S_CS_CHK) && w_fail) ||
                        ((r_state == S_CS_ADD) && w_j_last);
    assign w_prog_now = r_prog || (r_state == S_CS_ADD);
    assign w_done_now = r_done + (PW+1)'(r_state == S_CS_ADD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_proc_cnt <= 5'(bsa_pkg::MAX_PROCS);
            r_res_cnt  <= 4'(bsa_pkg::MAX_RES);
            r_vld      <= '0;
            r_ov       <= 1'b0;
            r_multi    <= 1'b0;
            r_clr      <= 1'b0;
            r_mode_req <= 1'b0;
            r_prog     <= 1'b0;
            r_done     <= '0;
            r_row      <= '0;
            r_j        <= '0;
            r_k        <= '0;
            for (int i = 0; i < bsa_pkg::MAX_RES; i++) begin
                r_free[i] <= '0;
                r_req[i]  <= '0;
            end
        end else begin
            r_rd_vld <= r_vld[w_raddr];
            if (w_we) begin
                r_vld[w_waddr] <= 1'b1;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == bsa_pkg::CFG_PROC_COUNT) begin
                    r_proc_cnt <= i_cfg_data;
                end else begin
                    r_res_cnt <= i_cfg_data[3:0];
                end
            end
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_multi <= 1'b0;
                        r_clr   <= 1'b0;
                        r_res   <= '{status: bsa_pkg::ST_ACCEPTED, order_proc: 4'd0, last: 1'b1};
                        r_state <= S_PUT;
                        unique case (i_in_data.opcode)
                            bsa_pkg::OP_SET_FREE: begin
                                r_free[i_in_data.res_index[RW-1:0]] <= i_in_data.amount;
                            end
                            bsa_pkg::OP_LOAD_ROW: begin
                                if (i_in_data.max_claim < i_in_data.amount) begin
                                    r_res.status <= bsa_pkg::ST_BAD_ROW;
                                end
                            end
                            bsa_pkg::OP_QUERY: begin
                                r_mode_req <= 1'b0;
                                r_state    <= S_CS_INIT;
                            end
                            bsa_pkg::OP_REQUEST: begin
                                r_req[i_in_data.res_index[RW-1:0]] <= i_in_data.amount;
                                if (i_in_data.req_last) begin
                                    r_clr <= 1'b1;
                                    if ({1'b0, i_in_data.proc_index} >= 5'(w_eff_n)) begin
                                        r_res.status <= bsa_pkg::ST_BAD_ROW;
                                    end else begin
                                        r_req_p <= i_in_data.proc_index[PW-1:0];
                                        r_j     <= '0;
                                        r_state <= S_RQ_RD;
                                    end
                                end
                            end
                            default: begin
                                r_state <= S_PUT;
                            end
                        endcase
                    end
                end
                S_CS_INIT: begin
                    for (int i = 0; i < bsa_pkg::MAX_RES; i++) begin
                        r_work[i] <= r_free[i];
                    end
                    r_fin   <= '0;
                    r_done  <= '0;
                    r_prog  <= 1'b0;
                    r_row   <= '0;
                    r_j     <= '0;
                    r_state <= S_CS_RD;
                end
                S_CS_RD: begin
                    r_state <= S_CS_CHK;
                end
                S_CS_CHK: begin
                    if (!w_fail) begin
                        if (w_j_last) begin
                            r_j     <= '0;
                            r_state <= S_CS_ARD;
                        end else begin
                            r_j     <= r_j + RW'(1);
                            r_state <= S_CS_RD;
                        end
                    end
                end
                S_CS_ARD: begin
                    r_state <= S_CS_ADD;
                end
                S_CS_ADD: begin
                    r_work[r_j] <= w_sat;
                    if (w_j_last) begin
                        r_ord[r_done[PW-1:0]] <= 4'(r_row);
                        r_fin[r_row]          <= 1'b1;
                        r_done                <= w_done_now;
                    end else begin
                        r_j     <= r_j + RW'(1);
                        r_state <= S_CS_ARD;
                    end
                end
                S_RQ_RD: begin
                    r_state <= S_RQ_CHK;
                end
                S_RQ_CHK: begin
                    if (r_req[r_j] > w_need) begin
                        r_res.status <= bsa_pkg::ST_OVER_NEED;
                        r_state      <= S_PUT;
                    end else if (r_req[r_j] > r_free[r_j]) begin
                        r_res.status <= bsa_pkg::ST_OVER_FREE;
                        r_state      <= S_PUT;
                    end else if (w_j_last) begin
                        r_j     <= '0;
                        r_state <= S_AP_RD;
                    end else begin
                        r_j     <= r_j + RW'(1);
                        r_state <= S_RQ_RD;
                    end
                end
                S_AP_RD: begin
                    r_state <= S_AP_WR;
                end
                S_AP_WR: begin
                    r_free[r_j] <= r_free[r_j] - r_req[r_j];
                    if (w_j_last) begin
                        r_mode_req <= 1'b1;
                        r_state    <= S_CS_INIT;
                    end else begin
                        r_j     <= r_j + RW'(1);
                        r_state <= S_AP_RD;
                    end
                end
                S_RB_RD: begin
                    r_state <= S_RB_WR;
                end
                S_RB_WR: begin
                    r_free[r_j] <= r_free[r_j] + r_req[r_j];
                    if (w_j_last) begin
                        r_res.status <= bsa_pkg::ST_ROLLBACK;
                        r_state      <= S_PUT;
                    end else begin
                        r_j     <= r_j + RW'(1);
                        r_state <= S_RB_RD;
                    end
                end
                S_PUT: begin
                    if (w_slot) begin
                        r_ov <= 1'b1;
                        if (r_multi) begin
                            r_od <= '{status: bsa_pkg::ST_SAFE, order_proc: r_ord[r_k],
                                      last: (r_k == w_n_last)};
                        end else begin
                            r_od <= r_res;
                        end
                        if (r_multi && (r_k != w_n_last)) begin
                            r_k <= r_k + PW'(1);
                        end else begin
                            r_multi <= 1'b0;
                            r_state <= S_IDLE;
                            if (r_clr) begin
                                r_clr <= 1'b0;
                                for (int i = 0; i < bsa_pkg::MAX_RES; i++) begin
                                    r_req[i] <= '0;
                                end
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_adv) begin
                r_j <= '0;
                if (w_done_now == w_eff_n) begin
                    if (r_mode_req) begin
                        r_res.status <= bsa_pkg::ST_GRANTED;
                        r_state      <= S_PUT;
                    end else begin
                        r_multi <= 1'b1;
                        r_k     <= '0;
                        r_state <= S_PUT;
                    end
                end else if (r_row == w_n_last) begin
                    if (w_prog_now) begin
                        r_row   <= '0;
                        r_prog  <= 1'b0;
                        r_state <= S_CS_RD;
                    end else if (r_mode_req) begin
                        r_state <= S_RB_RD;
                    end else begin
                        r_res   <= '{status: bsa_pkg::ST_UNSAFE, order_proc: 4'd0, last: 1'b1};
                        r_state <= S_PUT;
                    end
                end else begin
                    r_row   <= r_row + PW'(1);
                    r_prog  <= w_prog_now;
                    r_state <= S_CS_RD;
                end
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

`ifndef SYNTHESIS
    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CS_RD) || (r_state == S_CS_CHK) || (r_state == S_CS_ARD) ||
         (r_state == S_CS_ADD)) |-> (r_done <= w_eff_n))
        else $error("Safe order count exceeds the processes in use.");

    a_multi_in_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_multi |-> (r_state == S_PUT))
        else $error("Safe order emission outside the result state.");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_data.opcode == bsa_pkg::OP_QUERY)) |=> (r_state == S_CS_INIT))
        else $error("Safety query did not start the sequencer.");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PUT) && w_slot && !r_multi) |=> (o_out_valid && o_out_data.last))
        else $error("Final result beat not marked last.");
`endif

endmodule

[sim/tb_banker_safety_allocator.sv]
// Self-checking testbench of the banker's safety allocator: directed table, then random beats.
module tb_banker_safety_allocator;

    typedef struct packed {
        bsa_pkg::t_in_beat  beat;
        logic               has_exp;
        bsa_pkg::t_out_beat exp_beat;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    bsa_pkg::t_in_beat  i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    bsa_pkg::t_out_beat o_out_data;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [4:0]         i_cfg_data;

    logic [15:0] mdl_free [bsa_pkg::MAX_RES];
    logic [15:0] mdl_alloc [bsa_pkg::DEPTH];
    logic [15:0] mdl_need [bsa_pkg::DEPTH];
    logic [15:0] mdl_reqbuf [bsa_pkg::MAX_RES];
    logic [3:0]  mdl_order [bsa_pkg::MAX_PROCS];
    logic [4:0]  mdl_procs;
    logic [3:0]  mdl_res;

    bsa_pkg::t_out_beat result_queue [$];
    int          err_count;
    int          cycle_count;
    int          beat_count;
    int          result_count;
    int          query_count;
    int          grant_count;
    logic        quiet;

    banker_safety_allocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int used_procs();
        if (mdl_procs < 1) return 1;
        if (mdl_procs > bsa_pkg::MAX_PROCS) return bsa_pkg::MAX_PROCS;
        return mdl_procs;
    endfunction

    function automatic int used_res();
        if (mdl_res < 1) return 1;
        if (mdl_res > bsa_pkg::MAX_RES) return bsa_pkg::MAX_RES;
        return mdl_res;
    endfunction

    function automatic bit run_safety();
        logic [16:0] work [bsa_pkg::MAX_RES];
        bit          done_flag [bsa_pkg::MAX_PROCS];
        bit          progress;
        bit          fits;
        int          n;
        int          m;
        int          done;
        n = used_procs();
        m = used_res();
        done = 0;
        progress = 1'b1;
        for (int j = 0; j < m; j++) work[j] = {1'b0, mdl_free[j]};
        for (int i = 0; i < n; i++) done_flag[i] = 1'b0;
        while (progress) begin
            progress = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!done_flag[i]) begin
                    fits = 1'b1;
                    for (int j = 0; j < m; j++)
                        if ({1'b0, mdl_need[i*bsa_pkg::MAX_RES+j]} > work[j]) fits = 1'b0;
                    if (fits) begin
                        for (int j = 0; j < m; j++) begin
                            work[j] = work[j] + {1'b0, mdl_alloc[i*bsa_pkg::MAX_RES+j]};
                            if (work[j] > 17'hFFFF) work[j] = 17'hFFFF;
                        end
                        mdl_order[done] = i[3:0];
                        done++;
                        done_flag[i] = 1'b1;
                        progress = 1'b1;
                    end
                end
            end
        end
        return done == n;
    endfunction

    function automatic logic [2:0] judge_request(int p);
        int m;
        m = used_res();
        if (p >= used_procs()) return bsa_pkg::ST_BAD_ROW;
        for (int j = 0; j < m; j++) begin
            if (mdl_reqbuf[j] > mdl_need[p*bsa_pkg::MAX_RES+j]) return bsa_pkg::ST_OVER_NEED;
            if (mdl_reqbuf[j] > mdl_free[j]) return bsa_pkg::ST_OVER_FREE;
        end
        for (int j = 0; j < m; j++) begin
            mdl_free[j] -= mdl_reqbuf[j];
            mdl_alloc[p*bsa_pkg::MAX_RES+j] += mdl_reqbuf[j];
            mdl_need[p*bsa_pkg::MAX_RES+j] -= mdl_reqbuf[j];
        end
        if (run_safety()) return bsa_pkg::ST_GRANTED;
        for (int j = 0; j < m; j++) begin
            mdl_free[j] += mdl_reqbuf[j];
            mdl_alloc[p*bsa_pkg::MAX_RES+j] -= mdl_reqbuf[j];
            mdl_need[p*bsa_pkg::MAX_RES+j] += mdl_reqbuf[j];
        end
        return bsa_pkg::ST_ROLLBACK;
    endfunction

    function automatic bsa_pkg::t_out_beat mk(logic [2:0] st, logic [3:0] ord, logic lst);
        bsa_pkg::t_out_beat b;
        b.status = st;
        b.order_proc = ord;
        b.last = lst;
        return b;
    endfunction

    task automatic predict_beat(input bsa_pkg::t_in_beat b);
        logic [2:0] st;
        int         n;
        case (b.opcode)
            bsa_pkg::OP_SET_FREE: begin
                mdl_free[b.res_index] = b.amount;
                result_queue.push_back(mk(bsa_pkg::ST_ACCEPTED, 4'd0, 1'b1));
            end
            bsa_pkg::OP_LOAD_ROW: begin
                if (b.max_claim < b.amount) begin
                    result_queue.push_back(mk(bsa_pkg::ST_BAD_ROW, 4'd0, 1'b1));
                end else begin
                    mdl_alloc[{b.proc_index, b.res_index}] = b.amount;
                    mdl_need[{b.proc_index, b.res_index}] = b.max_claim - b.amount;
                    result_queue.push_back(mk(bsa_pkg::ST_ACCEPTED, 4'd0, 1'b1));
                end
            end
            bsa_pkg::OP_QUERY: begin
                query_count++;
                if (!run_safety()) begin
                    result_queue.push_back(mk(bsa_pkg::ST_UNSAFE, 4'd0, 1'b1));
                end else begin
                    n = used_procs();
                    for (int i = 0; i < n; i++)
                        result_queue.push_back(mk(bsa_pkg::ST_SAFE, mdl_order[i], i + 1 == n));
                end
            end
            default: begin
                mdl_reqbuf[b.res_index] = b.amount;
                if (!b.req_last) begin
                    result_queue.push_back(mk(bsa_pkg::ST_ACCEPTED, 4'd0, 1'b1));
                end else begin
                    st = judge_request(int'(b.proc_index));
                    if (st == bsa_pkg::ST_GRANTED) grant_count++;
                    for (int j = 0; j < bsa_pkg::MAX_RES; j++) mdl_reqbuf[j] = 16'd0;
                    result_queue.push_back(mk(st, 4'd0, 1'b1));
                end
            end
        endcase
    endtask

    task automatic send_beat(input bsa_pkg::t_in_beat b);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        predict_beat(b);
        beat_count++;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (result_queue.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [4:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == bsa_pkg::CFG_PROC_COUNT) mdl_procs = val;
        else mdl_res = val[3:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic bsa_pkg::t_in_beat rnd_beat(logic [1:0] op);
        logic [63:0]       raw;
        bsa_pkg::t_in_beat b;
        raw = {$urandom, $urandom};
        b = raw[$bits(bsa_pkg::t_in_beat)-1:0];
        b.opcode = op;
        if ($urandom_range(0, 3) != 0) begin
            b.amount = 16'($urandom_range(0, 12));
            b.max_claim = b.amount + 16'($urandom_range(0, 10));
        end
        if (op == bsa_pkg::OP_REQUEST) b.req_last = 1'b0;
        return b;
    endfunction

    function automatic bsa_pkg::t_in_beat dbeat(logic [1:0] op, int p, int r, int a, int mx,
                                                bit l);
        bsa_pkg::t_in_beat b;
        b.opcode = op;
        b.proc_index = p[3:0];
        b.res_index = r[2:0];
        b.amount = a[15:0];
        b.max_claim = mx[15:0];
        b.req_last = l;
        return b;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (cycle_count > 10000000) begin
                $display("timeout at %0t", $time);
                $display("DONE: errors detected");
                $finish;
            end
            if (o_out_valid && !i_out_stall) begin
                result_count <= result_count + 1;
                if (result_queue.size() == 0) begin
                    $display("%0t: expected no result actual %h", $time, o_out_data);
                    err_count++;
                end else begin
                    if (o_out_data.status !== result_queue[0].status ||
                        o_out_data.order_proc !== result_queue[0].order_proc ||
                        o_out_data.last !== result_queue[0].last) begin
                        $display("%0t: expected %h actual %h", $time,
                                 result_queue[0], o_out_data);
                        err_count++;
                    end
                    void'(result_queue.pop_front());
                end
            end
        end
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        t_dir_row rows [$];
        t_dir_row row;
        bsa_pkg::t_in_beat b;
        logic [2:0] head_st;
        int p;
        err_count = 0;
        cycle_count = 0;
        beat_count = 0;
        result_count = 0;
        query_count = 0;
        grant_count = 0;
        quiet = 1'b0;
        mdl_procs = 5'd16;
        mdl_res = 4'd8;
        for (int j = 0; j < bsa_pkg::MAX_RES; j++) begin
            mdl_free[j] = 16'd0;
            mdl_reqbuf[j] = 16'd0;
        end
        for (int k = 0; k < bsa_pkg::DEPTH; k++) begin
            mdl_alloc[k] = 16'd0;
            mdl_need[k] = 16'd0;
        end
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = bsa_pkg::CFG_PROC_COUNT;
        i_cfg_data = 5'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        row.has_exp = 1'b1;
        row.exp_beat = mk(bsa_pkg::ST_SAFE, 4'd0, 1'b0);
        row.beat = dbeat(bsa_pkg::OP_QUERY, 0, 0, 0, 0, 0);
        rows.push_back(row);
        row.exp_beat = mk(bsa_pkg::ST_BAD_ROW, 4'd0, 1'b1);
        row.beat = dbeat(bsa_pkg::OP_LOAD_ROW, 15, 7, 65535, 65534, 0);
        rows.push_back(row);
        row.exp_beat = mk(bsa_pkg::ST_ACCEPTED, 4'd0, 1'b1);
        row.beat = dbeat(bsa_pkg::OP_SET_FREE, 0, 7, 65535, 0, 0);
        rows.push_back(row);
        row.beat = dbeat(bsa_pkg::OP_LOAD_ROW, 0, 0, 65535, 65535, 1);
        rows.push_back(row);
        row.beat = dbeat(bsa_pkg::OP_LOAD_ROW, 3, 1, 0, 65535, 0);
        rows.push_back(row);
        row.beat = dbeat(bsa_pkg::OP_SET_FREE, 0, 1, 4, 0, 0);
        rows.push_back(row);
        row.beat = dbeat(bsa_pkg::OP_REQUEST, 3, 0, 0, 0, 0);
        rows.push_back(row);
        row.exp_beat = mk(bsa_pkg::ST_OVER_FREE, 4'd0, 1'b1);
        row.beat = dbeat(bsa_pkg::OP_REQUEST, 3, 1, 5, 0, 1);
        rows.push_back(row);
        row.exp_beat = mk(bsa_pkg::ST_OVER_NEED, 4'd0, 1'b1);
        row.beat = dbeat(bsa_pkg::OP_REQUEST, 0, 0, 1, 0, 1);
        rows.push_back(row);
        row.has_exp = 1'b0;
        row.beat = dbeat(bsa_pkg::OP_REQUEST, 3, 1, 4, 0, 1);
        rows.push_back(row);
        row.beat = dbeat(bsa_pkg::OP_QUERY, 0, 0, 0, 0, 0);
        rows.push_back(row);
        row.beat = dbeat(bsa_pkg::OP_LOAD_ROW, 5, 2, 0, 9, 0);
        rows.push_back(row);
        row.beat = dbeat(bsa_pkg::OP_QUERY, 0, 0, 0, 0, 0);
        rows.push_back(row);
        row.beat = dbeat(bsa_pkg::OP_REQUEST, 3, 1, 0, 0, 1);
        rows.push_back(row);
        row.beat = dbeat(bsa_pkg::OP_REQUEST, 15, 7, 65535, 65535, 1);
        rows.push_back(row);

        foreach (rows[k]) begin
            send_beat(rows[k].beat);
            if (rows[k].has_exp) begin
                head_st = result_queue[result_queue.size() -
                          (rows[k].beat.opcode == bsa_pkg::OP_QUERY ? used_procs() : 1)].status;
                if (head_st !== rows[k].exp_beat.status) begin
                    $display("%0t: directed row %0d expected %h actual %h", $time, k,
                             rows[k].exp_beat.status, head_st);
                    err_count++;
                end
            end
        end
        drain();

        write_cfg(bsa_pkg::CFG_PROC_COUNT, 5'd1);
        write_cfg(bsa_pkg::CFG_RES_COUNT, 5'd1);
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 4) quiet = 1'b1;
            for (int k = 0; k < 30; k++) begin
                case ($urandom_range(0, 9))
                    0, 1: b = rnd_beat(bsa_pkg::OP_SET_FREE);
                    2, 3, 4: b = rnd_beat(bsa_pkg::OP_LOAD_ROW);
                    5: b = rnd_beat(bsa_pkg::OP_QUERY);
                    default: begin
                        p = $urandom_range(0, 15);
                        for (int j = $urandom_range(0, 2); j > 0; j--) begin
                            b = rnd_beat(bsa_pkg::OP_REQUEST);
                            b.proc_index = p[3:0];
                            b.amount = 16'($urandom_range(0, 4));
                            send_beat(b);
                        end
                        b = rnd_beat(bsa_pkg::OP_REQUEST);
                        b.proc_index = p[3:0];
                        b.amount = 16'($urandom_range(0, 4));
                        b.req_last = 1'b1;
                    end
                endcase
                send_beat(b);
                if (k == 20 && phase == 2) begin
                    i_in_valid <= 1'b0;
                    while (result_queue.size() != 0) @(posedge i_clk);
                end
            end
            drain();
            case (phase)
                0: begin
                    write_cfg(bsa_pkg::CFG_PROC_COUNT, 5'd4);
                    write_cfg(bsa_pkg::CFG_RES_COUNT, 5'd3);
                end
                1: begin
                    write_cfg(bsa_pkg::CFG_PROC_COUNT, 5'd0);
                    write_cfg(bsa_pkg::CFG_RES_COUNT, 5'd15);
                end
                2: begin
                    write_cfg(bsa_pkg::CFG_PROC_COUNT, 5'd31);
                    write_cfg(bsa_pkg::CFG_RES_COUNT, 5'd0);
                end
                default: begin
                    write_cfg(bsa_pkg::CFG_PROC_COUNT, 5'd16);
                    write_cfg(bsa_pkg::CFG_RES_COUNT, 5'd8);
                end
            endcase
        end
        drain();
        @(posedge i_clk);
        $display("Run sent %0d beats and checked %0d results.", beat_count, result_count);
        $display("It made %0d safety queries and %0d granted requests.", query_count,
                 grant_count);
        if (err_count == 0 && result_queue.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
